/* src/matrix_multiply_top_macros.svh */
// Assertion macros shared by the matrix multiply RTL.
`ifndef MATRIX_MULTIPLY_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MMT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define MMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MMT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define MMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* src/mm_pkg.sv */
// Shared types, codes and helpers for the matrix multiply block.
package mm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  localparam int SIZE_W = 4;   // size register width
  localparam int IDX_W  = 3;   // row and column port width
  localparam int IN_W   = 16;  // element port width
  localparam int ACC_W  = 40;  // Q23.16 result width

  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_A_ROWS = 2'd0;
  localparam logic [1:0] CFG_A_COLS = 2'd1;
  localparam logic [1:0] CFG_B_ROWS = 2'd2;
  localparam logic [1:0] CFG_B_COLS = 2'd3;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd;
  } mm_mem_ctrl_t;

  // Zero acts as one, anything above the limit acts as the limit.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* src/mm_store.sv */
// Element stores for matrices A and B: one write port, registered reads.
module mm_store
  import mm_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  localparam int DEPTH     = MAX_DIM * MAX_DIM,
  localparam int ADDR_W    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  mm_mem_ctrl_t          ctrl,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [ELEM_WIDTH-1:0] wr_data,
  input  logic [ADDR_W-1:0]     rd_addr_a,
  input  logic [ADDR_W-1:0]     rd_addr_b,
  output logic [ELEM_WIDTH-1:0] rd_data_a,
  output logic [ELEM_WIDTH-1:0] rd_data_b
);

  logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] b_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_a) begin
      a_mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd) begin
      rd_data_a <= a_mem[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_b) begin
      b_mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd) begin
      rd_data_b <= b_mem[rd_addr_b];
    end
  end

endmodule

/* src/matrix_multiply_top.sv */
// Matrix multiply top level: command decode, dot-product sequencer and MAC pipeline.
//
// A write command (start with cmd write A or write B) leaves busy low.
// A compute command with matching sizes holds busy while it issues a_rows * b_cols * a_cols
// multiply-accumulates (effective sizes), one per cycle, limited by the single read port of
// each element store feeding the one multiplier, and while the read, multiply and accumulate
// stages drain. Each product element is shown
// for exactly one cycle with result_valid high, in row-major order, the final one with
// last_result set; there is no way to hold results off, so the receiver must take every
// beat. A size mismatch gives a single error beat in the cycle after the command, with busy
// staying low. Writes and reads of the stores never overlap since start is refused while
// busy. cfg_ready is always high; change the sizes only while the block is idle.
`include "matrix_multiply_top_macros.svh"

module matrix_multiply_top
  import mm_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              cmd,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        col_index,
  input  logic signed [IN_W-1:0]  element_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [SIZE_W-1:0]       cfg_data,
  output logic                    result_valid,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [ACC_W-1:0] product_value,
  output logic                    size_error,
  output logic                    last_result
);

  localparam int ADDR_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int PROD_W   = 2 * ELEM_WIDTH;
  localparam int SIZE_MAX = (1 << SIZE_W) - 1;
  localparam logic [SIZE_W-1:0] SIZE_LIM =
      SIZE_W'((MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  typedef struct packed {
    logic             first;
    logic             dot_last;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [SIZE_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [SIZE_W-1:0] ar, ac, bc;
  logic [SIZE_W-1:0] ar_eff, ac_eff, br_eff, bc_eff;
  logic [SIZE_W-1:0] i, j, k;

  logic accept, do_compute, mismatch, wr_in_range;

  mm_mem_ctrl_t          mem_ctrl;
  logic [ADDR_W-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  logic [ELEM_WIDTH-1:0] wr_data, rd_data_a, rd_data_b;

  tag_t tag0, tag1, tag2;
  logic v1, v2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext, acc, acc_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign ar_eff = eff_size(a_rows, SIZE_LIM);
  assign ac_eff = eff_size(a_cols, SIZE_LIM);
  assign br_eff = eff_size(b_rows, SIZE_LIM);
  assign bc_eff = eff_size(b_cols, SIZE_LIM);
  assign mismatch   = (ac_eff != br_eff);
  assign do_compute = accept && (cmd == CMD_COMPUTE);

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= SIZE_W'(8);
      a_cols <= SIZE_W'(8);
      b_rows <= SIZE_W'(8);
      b_cols <= SIZE_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_A_ROWS: a_rows <= cfg_data;
        CFG_A_COLS: a_cols <= cfg_data;
        CFG_B_ROWS: b_rows <= cfg_data;
        CFG_B_COLS: b_cols <= cfg_data;
        default:    a_rows <= a_rows;
      endcase
    end
  end

  // Store access: writes only while idle, reads only while issuing
  assign wr_in_range   = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
  assign mem_ctrl.wr_a = accept && (cmd == CMD_WRITE_A) && wr_in_range;
  assign mem_ctrl.wr_b = accept && (cmd == CMD_WRITE_B) && wr_in_range;
  assign mem_ctrl.rd   = (state == ST_ISSUE);
  assign wr_addr   = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));
  assign wr_data   = ELEM_WIDTH'($unsigned(element_value));
  assign rd_addr_a = ADDR_W'(int'(i) * MAX_DIM + int'(k));
  assign rd_addr_b = ADDR_W'(int'(k) * MAX_DIM + int'(j));

  mm_store #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_store (
    .clk       (clk),
    .ctrl      (mem_ctrl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Tag for the element pair being read this cycle
  assign tag0.first    = (k == '0);
  assign tag0.dot_last = (k == ac - SIZE_W'(1));
  assign tag0.last     = tag0.dot_last && (j == bc - SIZE_W'(1)) && (i == ar - SIZE_W'(1));
  assign tag0.row      = IDX_W'(i);
  assign tag0.col      = IDX_W'(j);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_compute && !mismatch) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (tag0.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v2 && tag2.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop counters: k innermost, then j, then i
  always_ff @(posedge clk) begin
    if (do_compute) begin
      ar <= ar_eff;
      ac <= ac_eff;
      bc <= bc_eff;
      i  <= '0;
      j  <= '0;
      k  <= '0;
    end else if (state == ST_ISSUE) begin
      if (!tag0.dot_last) begin
        k <= k + SIZE_W'(1);
      end else begin
        k <= '0;
        if (j != bc - SIZE_W'(1)) begin
          j <= j + SIZE_W'(1);
        end else begin
          j <= '0;
          i <= i + SIZE_W'(1);
        end
      end
    end
  end

  // Read, multiply and accumulate stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_ISSUE);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= tag0;
    tag2 <= tag1;
    prod <= $signed(rd_data_a) * $signed(rd_data_b);
  end

  // Low 40 bits of the sign-extended product carry the sum modulo 2^40
  assign prod_ext = ACC_W'(prod);
  assign acc_next = tag2.first ? prod_ext : acc + prod_ext;

  always_ff @(posedge clk) begin
    if (v2) begin
      acc <= acc_next;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (do_compute && mismatch) || (v2 && tag2.dot_last);
    end
  end

  always_ff @(posedge clk) begin
    if (do_compute && mismatch) begin
      out_row       <= '0;
      out_col       <= '0;
      product_value <= '0;
      size_error    <= 1'b1;
      last_result   <= 1'b1;
    end else if (v2 && tag2.dot_last) begin
      out_row       <= tag2.row;
      out_col       <= tag2.col;
      product_value <= acc_next;
      size_error    <= 1'b0;
      last_result   <= tag2.last;
    end
  end

  `MMT_ASSERT_NOW(a_final_beat_idle, clk, rst, result_valid && last_result, !busy, "final beat while still busy")
  `MMT_ASSERT_NOW(a_error_beat_shape, clk, rst, result_valid && size_error, last_result && out_row == '0 && out_col == '0 && product_value == '0, "malformed error beat")
  `MMT_ASSERT_NOW(a_pipe_empty_idle, clk, rst, state == ST_IDLE, !v1 && !v2, "pipeline holds work while idle")
  `MMT_ASSERT_NOW(a_inner_bound, clk, rst, state == ST_ISSUE, k < ac && j < bc && i < ar, "loop counter past its size")
  `MMT_ASSERT_NEXT(a_no_store_write_busy, clk, rst, busy, !(mem_ctrl.wr_a || mem_ctrl.wr_b) || !busy, "store written while computing")

endmodule
